@@ hw/rtl/irpc_pkg.sv @@
`default_nettype none

package irpc_pkg;

    // Widths fixed by the item and register formats
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned CODE_W     = 16;
    localparam int unsigned BUTTON_W   = 4;
    localparam int unsigned CFG_DATA_W = 16;

    // Preamble window length and default code length
    localparam int unsigned SYNC_LEN          = 16;
    localparam int unsigned CODE_BITS_DEFAULT = 16;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] BIT_THRESHOLD_RST = 16'd40000;
    localparam logic [CFG_DATA_W-1:0] SYNC_PATTERN_RST  = 16'd765;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_BIT_THRESHOLD = 1'b0,
        CFG_SYNC_PATTERN  = 1'b1
    } cfg_index_t;

    // Button codes
    localparam int unsigned NUM_BUTTONS = 12;
    localparam logic [BUTTON_W-1:0] BTN_UNKNOWN = 4'd12;

    localparam logic [15:0] BUTTON_CODES [NUM_BUTTONS] = '{
        16'd255,   16'd32895, 16'd16575, 16'd49215,
        16'd8415,  16'd41055, 16'd24735, 16'd57375,
        16'd4335,  16'd36975, 16'd765,   16'd2295
    };

    // Per-cell control: shift in the neighbor's bit, or clear
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/irpc_ifs.sv @@
`default_nettype none

interface irpc_pulse_if;
    import irpc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [INTERVAL_W-1:0] pulse_interval;

    modport source (output valid, output pulse_interval, input ready);
    modport sink   (input valid, input pulse_interval, output ready);
endinterface

interface irpc_code_if;
    import irpc_pkg::*;

    logic                valid;
    logic                ready;
    logic [CODE_W-1:0]   code_word;
    logic [BUTTON_W-1:0] button;

    modport source (output valid, output code_word, output button, input ready);
    modport sink   (input valid, input code_word, input button, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/irpc_bit_cell.sv @@
`default_nettype none

module irpc_bit_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire irpc_pkg::cell_ctl_t ctl,
    input  wire logic                bit_in,
    output logic                     bit_out
);
    import irpc_pkg::*;

    logic bit_reg;
    logic bit_next;

    // Clear wins over shift
    always_comb
    begin
        priority if (ctl.clear)
        begin
            bit_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            bit_next = bit_in;
        end
        else
        begin
            bit_next = bit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    assign bit_out = bit_reg;

endmodule

`default_nettype wire

@@ hw/rtl/irpc_button_match.sv @@
`default_nettype none

module irpc_button_match #(
    parameter int unsigned CODE_BITS = irpc_pkg::CODE_BITS_DEFAULT
) (
    input  wire logic [CODE_BITS-1:0]          code,
    output logic      [irpc_pkg::BUTTON_W-1:0] button
);
    import irpc_pkg::*;

    localparam int unsigned EXT_W = CODE_BITS + 16;

    logic [EXT_W-1:0] code_ext;

    assign code_ext = {16'b0, code};

    // Compare against every button code; lowest index wins
    always_comb
    begin
        button = BTN_UNKNOWN;
        for (int k = NUM_BUTTONS - 1; k >= 0; k--)
        begin
            if (code_ext == EXT_W'(BUTTON_CODES[k]))
            begin
                button = BUTTON_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ir_pulse_code_receiver_top.sv @@
// Channel  Direction  Payload                       Transaction
// pulse    in         pulse_interval[15:0]          valid && ready
// code     out        code_word[15:0], button[3:0]  valid && ready
//
// One pulse transaction per cycle while pulse.ready is high; its bit enters the cell chains in that cycle.
// A code result is registered and shows on the code channel in the cycle after
// the transaction that carries the last data bit.
// pulse.ready drops only while a finished code waits and code.ready is low.
// Reset clears all cells, counters and flags at once; no clearing pass.
`default_nettype none

module ir_pulse_code_receiver_top #(
    parameter int unsigned CODE_BITS = irpc_pkg::CODE_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [0:0]                        cfg_index,
    input  wire logic [irpc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    irpc_pulse_if.sink                             pulse,
    irpc_code_if.source                            code
);
    import irpc_pkg::*;

    localparam int unsigned CNT_MAX = (CODE_BITS > SYNC_LEN) ? CODE_BITS : SYNC_LEN;
    localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);

    // Configuration registers
    logic [CFG_DATA_W-1:0] threshold_reg;
    logic [CFG_DATA_W-1:0] sync_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= BIT_THRESHOLD_RST;
            sync_reg      <= SYNC_PATTERN_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_BIT_THRESHOLD)
            begin
                threshold_reg <= cfg_wdata;
            end
            else
            begin
                sync_reg <= cfg_wdata;
            end
        end
    end

    // Handshake
    logic code_valid_reg;
    logic accept;
    logic rx_bit;

    assign pulse.ready = !code_valid_reg || code.ready;
    assign accept      = pulse.valid && pulse.ready;
    assign rx_bit      = !(pulse.pulse_interval > threshold_reg);

    // Control state
    logic             capturing_reg;
    logic             capturing_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_inc;
    logic             sync_hit;
    logic             code_done;

    // Cell chains; the newest bit of each window is taken from the incoming
    // bit, so the chains hold one bit less than the window
    logic [SYNC_LEN-2:0]  recent_q;
    logic [SYNC_LEN-1:0]  recent_new;
    logic [CODE_BITS-2:0] data_q;
    logic [CODE_BITS-1:0] data_new;
    cell_ctl_t            recent_ctl;
    cell_ctl_t            data_ctl;

    assign recent_new = {recent_q[SYNC_LEN-2:0], rx_bit};
    assign data_new   = {data_q[CODE_BITS-2:0], rx_bit};

    // Count seen bits while hunting (saturating), data bits while capturing
    always_comb
    begin
        if (!capturing_reg && count_reg >= CNT_W'(SYNC_LEN))
        begin
            count_inc = count_reg;
        end
        else
        begin
            count_inc = count_reg + CNT_W'(1);
        end
    end

    assign sync_hit  = accept && !capturing_reg && count_inc >= CNT_W'(SYNC_LEN)
                       && recent_new == sync_reg;
    assign code_done = accept && capturing_reg && count_inc == CNT_W'(CODE_BITS);

    // Next control state
    always_comb
    begin
        capturing_next = capturing_reg;
        count_next     = count_reg;
        priority if (code_done || sync_hit)
        begin
            capturing_next = sync_hit;
            count_next     = '0;
        end
        else if (accept)
        begin
            count_next = count_inc;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capturing_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            capturing_reg <= capturing_next;
            count_reg     <= count_next;
        end
    end

    // Drive the cell chains
    always_comb
    begin
        recent_ctl.shift = accept && !capturing_reg;
        recent_ctl.clear = code_done;
        data_ctl.shift   = accept && capturing_reg;
        data_ctl.clear   = code_done || sync_hit;
    end

    generate
        for (genvar i = 0; i < SYNC_LEN - 1; i++)
        begin : g_recent
            irpc_bit_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (recent_ctl),
                .bit_in  ((i == 0) ? rx_bit : recent_q[(i == 0) ? 0 : i - 1]),
                .bit_out (recent_q[i])
            );
        end

        for (genvar j = 0; j < CODE_BITS - 1; j++)
        begin : g_data
            irpc_bit_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (data_ctl),
                .bit_in  ((j == 0) ? rx_bit : data_q[(j == 0) ? 0 : j - 1]),
                .bit_out (data_q[j])
            );
        end
    endgenerate

    // Button lookup on the completed code
    logic [BUTTON_W-1:0] button_match;

    irpc_button_match #(
        .CODE_BITS (CODE_BITS)
    ) u_button_match (
        .code   (data_new),
        .button (button_match)
    );

    // Output register
    logic [CODE_W-1:0]   code_word_reg;
    logic [BUTTON_W-1:0] button_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_valid_reg <= 1'b0;
        end
        else if (code_done)
        begin
            code_valid_reg <= 1'b1;
        end
        else if (code.ready)
        begin
            code_valid_reg <= 1'b0;
        end
    end

    // Keep the low code bits, zero-filled for short codes
    always_ff @(posedge clk)
    begin
        if (code_done)
        begin
            code_word_reg <= CODE_W'(data_new);
            button_reg    <= button_match;
        end
    end

    assign code.valid     = code_valid_reg;
    assign code.code_word = code_word_reg;
    assign code.button    = button_reg;

endmodule

`default_nettype wire

@@ hw/rtl/irpc_checker.sv @@
`default_nettype none

module irpc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] out_code_word,
    input wire logic [3:0]  out_button
);
    import irpc_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_code_word)
                                    && $stable(out_button))
        else $error("code result changed while stalled");

    // Input is taken whenever the output slot is free
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pulse input stalled with empty output");

    // A new result follows an accepted pulse
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("code result without a pulse transaction");

    // Button stays within its range
    a_button_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_button <= BTN_UNKNOWN)
        else $error("button out of range");

    // Button zero carries its code
    a_button_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_button == 4'd0 |-> out_code_word == BUTTON_CODES[0])
        else $error("button zero with wrong code word");

endmodule

bind ir_pulse_code_receiver_top irpc_checker u_irpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pulse.valid),
    .in_ready      (pulse.ready),
    .out_valid     (code.valid),
    .out_ready     (code.ready),
    .out_code_word (code.code_word),
    .out_button    (code.button)
);

`default_nettype wire
